[design/kwms_pkg.sv]
package kwms_pkg;

  localparam int VAL_W        = 32;
  localparam int RUN_W        = 3;
  localparam int CFG_W        = 4;
  localparam int DEF_MAX_RUNS = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic [RUN_W-1:0] run_index;
    logic [VAL_W-1:0] head_value;
    logic             exhausted;
    logic             in_range;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } qhead_t;

endpackage

[design/kwms_ram.sv]
module kwms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/kwms_front.sv]
module kwms_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [kwms_pkg::RUN_W-1:0]     in_run_index,
  input  logic signed [kwms_pkg::VAL_W-1:0] in_head_value,
  input  logic                           in_exhausted,
  input  logic [kwms_pkg::CFG_W-1:0]     n_eff,
  output kwms_pkg::qhead_t               q_head,
  input  logic                           q_pop
);

  import kwms_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;
  item_t            new_item;

  assign in_full = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && (cnt_r != '0);

  // tag words for runs outside the active set so the back end drops them
  always_comb begin
    new_item.run_index  = in_run_index;
    new_item.head_value = in_head_value;
    new_item.exhausted  = in_exhausted;
    new_item.in_range   = (int'(in_run_index) < int'(n_eff));
  end

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      wptr_nxt = (int'(wptr_r) == QUEUE_DEPTH - 1) ? '0 : wptr_r + 1'b1;
    end
    if (pop_ok) begin
      rptr_nxt = (int'(rptr_r) == QUEUE_DEPTH - 1) ? '0 : rptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push_ok) begin
      ent_r[wptr_r] <= new_item;
    end
  end

  assign q_head.avail = (cnt_r != '0);
  assign q_head.item  = ent_r[rptr_r];

endmodule

[design/kwms_back.sv]
module kwms_back #(
  parameter int MAX_RUNS = kwms_pkg::DEF_MAX_RUNS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [kwms_pkg::CFG_W-1:0]        n_eff,
  input  kwms_pkg::qhead_t                  q_head,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [kwms_pkg::VAL_W-1:0] out_merged_value,
  output logic [kwms_pkg::RUN_W-1:0]        out_source_run,
  output logic                              out_all_done
);

  import kwms_pkg::*;

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int EXT_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [MAX_RUNS-1:0]       valid_r, valid_nxt;
  logic [MAX_RUNS-1:0]       fin_r, fin_nxt;
  logic                      done_rep_r, done_rep_nxt;
  logic [CFG_W-1:0]          issue_r, issue_nxt;
  logic                      pend_r, pend_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      found_r, found_nxt;
  logic signed [VAL_W-1:0]   best_val_r, best_val_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic                      out_full_r, out_full_nxt;
  logic signed [VAL_W-1:0]   out_val_r, out_val_nxt;
  logic [RUN_W-1:0]          out_run_r, out_run_nxt;
  logic                      out_done_r, out_done_nxt;

  logic [MAX_RUNS-1:0]       in_use;
  logic                      all_ready;
  logic                      any_valid;
  logic                      out_free;
  logic [EXT_W-1:0]          wr_ext;
  logic [EXT_W-1:0]          issue_ext;
  logic [EXT_W-1:0]          best_ext;
  logic [IDX_W-1:0]          wr_addr;
  logic [IDX_W-1:0]          rd_addr;
  logic                      ram_we;
  logic [VAL_W-1:0]          ram_rdata;

  assign wr_ext    = EXT_W'(q_head.item.run_index);
  assign wr_addr   = wr_ext[IDX_W-1:0];
  assign issue_ext = EXT_W'(issue_r);
  assign rd_addr   = issue_ext[IDX_W-1:0];
  assign best_ext  = EXT_W'(best_idx_r);

  kwms_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_RUNS)
  ) u_heads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (q_head.item.head_value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < MAX_RUNS; i++) begin
      in_use[i] = (int'(n_eff) > i);
    end
    all_ready = &(valid_r | fin_r | ~in_use);
    any_valid = |(valid_r & in_use);
  end

  assign out_free = !out_full_r || out_pop;

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    fin_nxt      = fin_r;
    done_rep_nxt = done_rep_r;
    issue_nxt    = issue_r;
    pend_nxt     = pend_r;
    rd_idx_nxt   = rd_idx_r;
    found_nxt    = found_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    out_full_nxt = out_full_r;
    out_val_nxt  = out_val_r;
    out_run_nxt  = out_run_r;
    out_done_nxt = out_done_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;

    if (out_pop) begin
      out_full_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_head.avail) begin
          q_pop     = 1'b1;
          state_nxt = ST_CHECK;
          if (q_head.item.in_range) begin
            if (q_head.item.exhausted) begin
              fin_nxt[wr_addr]   = 1'b1;
              valid_nxt[wr_addr] = 1'b0;
            end else if (!fin_r[wr_addr]) begin
              ram_we             = 1'b1;
              valid_nxt[wr_addr] = 1'b1;
            end
          end
        end
      end
      ST_CHECK: begin
        if (!all_ready) begin
          state_nxt = ST_IDLE;
        end else if (any_valid) begin
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end else if (!done_rep_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // read one head per cycle, compare it the cycle after
        if (issue_r != n_eff) begin
          pend_nxt   = 1'b1;
          rd_idx_nxt = rd_addr;
          issue_nxt  = issue_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // strict less keeps the lowest run on ties
        if (pend_r && valid_r[rd_idx_r] &&
            (!found_r || ($signed(ram_rdata) < best_val_r))) begin
          found_nxt    = 1'b1;
          best_val_nxt = $signed(ram_rdata);
          best_idx_nxt = rd_idx_r;
        end
        if (pend_r && (issue_r == n_eff)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_full_nxt          = 1'b1;
          out_val_nxt           = best_val_r;
          out_run_nxt           = best_ext[RUN_W-1:0];
          out_done_nxt          = 1'b0;
          valid_nxt[best_idx_r] = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_full_nxt = 1'b1;
          out_val_nxt  = '0;
          out_run_nxt  = '0;
          out_done_nxt = 1'b1;
          done_rep_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      fin_r      <= '0;
      done_rep_r <= 1'b0;
      issue_r    <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      fin_r      <= fin_nxt;
      done_rep_r <= done_rep_nxt;
      issue_r    <= issue_nxt;
      pend_r     <= pend_nxt;
      found_r    <= found_nxt;
      out_full_r <= out_full_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_run_r  <= out_run_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_empty        = !out_full_r;
  assign out_merged_value = out_val_r;
  assign out_source_run   = out_run_r;
  assign out_all_done     = out_done_r;

endmodule

[design/kway_merge_selector.sv]
// K-way merge selector for the merge phase of an external sort.
// Input queue: present run_index, head_value and exhausted with in_push;
// a word is taken at a clock edge where in_push is high and in_full low.
// A word for a run in use refills its head or marks it exhausted. Once every
// run in use holds a head or is exhausted, the smallest head and its run
// come out (ties to the lowest run); refill that run next. When all runs
// are exhausted, one word with all_done set comes out, then nothing more.
// Output queue: a word waits on the out_ ports while out_empty is low and
// is taken at an edge where out_pop is high.
// Config: cfg_runs_in_use is written on cfg_valid (cfg_ready is always
// high); write it only while the block is idle. Reset sets 8 runs and
// clears all head and exhausted marks.
// Back end: a word passes the idle and check steps; if a selection is due,
// a scan reads one head per cycle from the head RAM across the runs in use,
// then the emit step. A two-entry input queue keeps taking words while the
// back end works. A held result stalls the back end at its emit step; the
// input stalls only once the queue has filled behind it.
module kway_merge_selector #(
  parameter int MAX_RUNS = kwms_pkg::DEF_MAX_RUNS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [kwms_pkg::RUN_W-1:0]        in_run_index,
  input  logic signed [kwms_pkg::VAL_W-1:0] in_head_value,
  input  logic                              in_exhausted,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [kwms_pkg::VAL_W-1:0] out_merged_value,
  output logic [kwms_pkg::RUN_W-1:0]        out_source_run,
  output logic                              out_all_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kwms_pkg::CFG_W-1:0]        cfg_runs_in_use
);

  import kwms_pkg::*;

  logic [CFG_W-1:0] runs_r, runs_nxt;
  logic [CFG_W-1:0] n_eff;
  qhead_t           q_head;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    runs_nxt = runs_r;
    if (cfg_valid && cfg_ready) begin
      runs_nxt = cfg_runs_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_r <= CFG_RESET;
    end else begin
      runs_r <= runs_nxt;
    end
  end

  // zero acts as one run, anything past the storage as all of it
  always_comb begin
    if (runs_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (int'(runs_r) > MAX_RUNS) begin
      n_eff = CFG_W'(MAX_RUNS);
    end else begin
      n_eff = runs_r;
    end
  end

  kwms_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_run_index  (in_run_index),
    .in_head_value (in_head_value),
    .in_exhausted  (in_exhausted),
    .n_eff         (n_eff),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  kwms_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .n_eff            (n_eff),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_merged_value (out_merged_value),
    .out_source_run   (out_source_run),
    .out_all_done     (out_all_done)
  );

endmodule
